/* rtl/core/udec_pkg.sv */
// package for the data eeprom controller: sizes, register codes, control bits
// no dependencies
`timescale 1ns / 1ps

package udec_pkg;

    localparam int ADDR_BITS = 10;
    localparam int HIGH_BITS = ADDR_BITS - 8;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int DATA_BITS = 8;
    localparam int DUR_BITS  = 16;

    localparam logic [DUR_BITS-1:0] DUR_RESET = 16'd16;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [2:0] SEL_ADDR_HI = 3'd0;
    localparam logic [2:0] SEL_ADDR_LO = 3'd1;
    localparam logic [2:0] SEL_DATA    = 3'd2;
    localparam logic [2:0] SEL_CTRL    = 3'd3;
    localparam logic [2:0] SEL_UNLOCK  = 3'd4;

    localparam int CTRL_EEPGD = 7;
    localparam int CTRL_CFGS  = 6;
    localparam int CTRL_WREN  = 2;
    localparam int CTRL_WR    = 1;
    localparam int CTRL_RD    = 0;

    localparam logic [1:0] UNLOCK_NONE = 2'd0;
    localparam logic [1:0] UNLOCK_ONE  = 2'd1;
    localparam logic [1:0] UNLOCK_TWO  = 2'd2;

    localparam logic [DATA_BITS-1:0] KEY_FIRST  = 8'h55;
    localparam logic [DATA_BITS-1:0] KEY_SECOND = 8'hAA;
    localparam logic [DATA_BITS-1:0] ERASED     = 8'hFF;

endpackage

/* rtl/core/udec_if.sv */
// valid/ready channel interfaces for the input and result transactions
// depends on udec_pkg
`timescale 1ns / 1ps

interface udec_in_if import udec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [2:0]           reg_select;
    logic [DATA_BITS-1:0] wdata;

    modport source (output valid, output func, output reg_select, output wdata, input ready);
    modport sink   (input valid, input func, input reg_select, input wdata, output ready);
endinterface

interface udec_out_if import udec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] rdata;
    logic                 write_busy;

    modport source (output valid, output rdata, output write_busy, input ready);
    modport sink   (input valid, input rdata, input write_busy, output ready);
endinterface

/* rtl/core/udec_ram.sv */
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module udec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/unlocked_data_eeprom_controller_unit.sv */
// top level of the register-mapped data eeprom controller
// depends on udec_pkg, udec_if and udec_ram
`timescale 1ns / 1ps

// One input transaction (register read, register write or time tick) is taken per
// cycle while the unit is idle and the result register is free or being drained,
// and each gives one result transaction. A control write that sets RD with the data
// space selected passes through the read state, as the cell memory read port is
// registered: the byte is read, then loaded into the data latch and, when WR
// starts in the same write, written back. After reset a clearing pass fills all
// 1024 cells with 0xFF; no input is taken during it, configuration writes are.

module unlocked_data_eeprom_controller_unit import udec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    udec_in_if.sink             i_in,
    udec_out_if.source          o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DUR_BITS-1:0] i_cfg_data
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RMW} t_state;

    t_state                 r_state, n_state;
    logic [ADDR_BITS-1:0]   r_clr_cnt, n_clr_cnt;
    logic [HIGH_BITS-1:0]   r_addr_hi, n_addr_hi;
    logic [7:0]             r_addr_lo, n_addr_lo;
    logic [DATA_BITS-1:0]   r_data, n_data;
    logic                   r_wren, n_wren;
    logic [1:0]             r_space, n_space;
    logic [1:0]             r_unlock, n_unlock;
    logic                   r_busy, n_busy;
    logic [DUR_BITS-1:0]    r_ticks, n_ticks;
    logic [DUR_BITS-1:0]    r_duration;
    logic                   r_pend_wr, n_pend_wr;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_BITS-1:0]   r_out_rdata, n_out_rdata;
    logic                   r_out_busy, n_out_busy;

    logic                   in_ready;
    logic                   accept;
    logic [ADDR_BITS-1:0]   cur_addr;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [DATA_BITS-1:0]   ram_wdata;
    logic [DATA_BITS-1:0]   ram_q;
    logic [DATA_BITS-1:0]   rd;
    logic [DATA_BITS-1:0]   v;
    logic                   go_rd;
    logic                   go_wr;

    assign cur_addr    = {r_addr_hi, r_addr_lo};
    assign in_ready    = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.rdata      = r_out_rdata;
    assign o_out.write_busy = r_out_busy;
    assign o_cfg_ready = 1'b1;

    udec_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cur_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_addr_hi   = r_addr_hi;
        n_addr_lo   = r_addr_lo;
        n_data      = r_data;
        n_wren      = r_wren;
        n_space     = r_space;
        n_unlock    = r_unlock;
        n_busy      = r_busy;
        n_ticks     = r_ticks;
        n_pend_wr   = r_pend_wr;
        n_out_valid = r_out_valid;
        n_out_rdata = r_out_rdata;
        n_out_busy  = r_out_busy;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = r_data;
        rd          = '0;
        v           = i_in.wdata;
        go_rd       = 1'b0;
        go_wr       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = ERASED;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_BITS'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_in.func)
                        FUNC_READ: begin
                            case (i_in.reg_select)
                                SEL_ADDR_HI: rd = DATA_BITS'(r_addr_hi);
                                SEL_ADDR_LO: rd = r_addr_lo;
                                SEL_DATA:    rd = r_data;
                                SEL_CTRL: begin
                                    rd = '0;
                                    rd[CTRL_EEPGD] = r_space[1];
                                    rd[CTRL_CFGS]  = r_space[0];
                                    rd[CTRL_WREN]  = r_wren;
                                    rd[CTRL_WR]    = r_busy;
                                end
                                default: rd = '0;
                            endcase
                            n_unlock = UNLOCK_NONE;
                        end
                        FUNC_WRITE: begin
                            n_unlock = UNLOCK_NONE;
                            case (i_in.reg_select)
                                SEL_ADDR_HI: n_addr_hi = v[HIGH_BITS-1:0];
                                SEL_ADDR_LO: n_addr_lo = v;
                                SEL_DATA:    n_data = v;
                                SEL_CTRL: begin
                                    n_space = {v[CTRL_EEPGD], v[CTRL_CFGS]};
                                    n_wren  = v[CTRL_WREN];
                                    go_rd   = v[CTRL_RD] && !v[CTRL_EEPGD] && !v[CTRL_CFGS];
                                    go_wr   = v[CTRL_WR] && !r_busy && (r_unlock == UNLOCK_TWO)
                                              && v[CTRL_WREN] && !v[CTRL_EEPGD]
                                              && !v[CTRL_CFGS];
                                    if (go_wr) begin
                                        n_busy  = 1'b1;
                                        n_ticks = (r_duration == '0) ? DUR_BITS'(1) : r_duration;
                                    end
                                    if (go_rd) begin
                                        n_state   = S_RMW;
                                        n_pend_wr = go_wr;
                                    end else if (go_wr) begin
                                        ram_we = 1'b1;
                                    end
                                end
                                SEL_UNLOCK: begin
                                    if (v == KEY_FIRST) begin
                                        n_unlock = UNLOCK_ONE;
                                    end else if (v == KEY_SECOND && r_unlock == UNLOCK_ONE) begin
                                        n_unlock = UNLOCK_TWO;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        FUNC_TICK: begin
                            if (r_busy) begin
                                if (r_ticks > DUR_BITS'(1)) begin
                                    n_ticks = r_ticks - DUR_BITS'(1);
                                end else begin
                                    n_ticks = '0;
                                    n_busy  = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (!go_rd) begin
                        n_out_valid = 1'b1;
                        n_out_rdata = rd;
                        n_out_busy  = n_busy;
                    end
                end
            end
            S_RMW: begin
                n_data = ram_q;
                if (r_pend_wr) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_q;
                end
                n_out_valid = 1'b1;
                n_out_rdata = '0;
                n_out_busy  = r_busy;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_addr_hi   <= '0;
            r_addr_lo   <= '0;
            r_data      <= '0;
            r_wren      <= 1'b0;
            r_space     <= '0;
            r_unlock    <= UNLOCK_NONE;
            r_busy      <= 1'b0;
            r_ticks     <= '0;
            r_duration  <= DUR_RESET;
            r_pend_wr   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_addr_hi   <= n_addr_hi;
            r_addr_lo   <= n_addr_lo;
            r_data      <= n_data;
            r_wren      <= n_wren;
            r_space     <= n_space;
            r_unlock    <= n_unlock;
            r_busy      <= n_busy;
            r_ticks     <= n_ticks;
            r_pend_wr   <= n_pend_wr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_duration <= i_cfg_data;
            end
        end
        r_out_rdata <= n_out_rdata;
        r_out_busy  <= n_out_busy;
    end

endmodule

/* rtl/core/udec_checker.sv */
// port-level checks for the data eeprom controller, bound to the top level
// depends on udec_pkg and unlocked_data_eeprom_controller_unit
`timescale 1ns / 1ps

module udec_props import udec_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [DATA_BITS-1:0] i_out_rdata,
    input logic                 i_out_busy
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // clearing pass follows every reset
    a_reset_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input taken right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rdata)
        && $stable(i_out_busy))
        else $error("stalled result changed");

    // every transaction is followed by a valid result or by a stall of the input, as in the read state
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid || !i_in_ready)
        else $error("no result after transaction");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc) || $past(in_acc, 2))
        else $error("result without transaction");

endmodule

bind unlocked_data_eeprom_controller_unit udec_props u_udec_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rdata (o_out.rdata),
    .i_out_busy  (o_out.write_busy)
);
